// ===== hw/rtl/i8mm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i8mm_pkg: shared constants and types for the int8 matrix multiply block
// Sizes, field widths, operation and register codes, controller/datapath
// command and status structs.
// ----------------------------------------------------------------------------
package i8mm_pkg;

    // Tile storage limits
    localparam int MAX_ROWS  = 16;
    localparam int MAX_COLS  = 16;
    localparam int MAX_DEPTH = 64;

    // Field widths
    localparam int OP_W    = 2;
    localparam int IDX_W   = 6;
    localparam int ELEM_W  = 8;
    localparam int SUM_W   = 22;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W   = 7;
    localparam int ROWS_W  = 5;
    localparam int COLS_W  = 5;
    localparam int DEPTH_W = 7;

    // Derived sizes
    localparam int A_DEPTH = MAX_ROWS * MAX_DEPTH;
    localparam int B_DEPTH = MAX_DEPTH * MAX_COLS;
    localparam int A_AW    = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
    localparam int B_AW    = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
    localparam int DEP_AW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CNT_W   = $clog2(MAX_DEPTH + 1);
    localparam int ACC_RAW = 2 * ELEM_W + 1 + $clog2(MAX_DEPTH + 1);
    localparam int ACC_W   = (ACC_RAW < SUM_W + 2) ? SUM_W + 2 : ACC_RAW;

    // Operation codes
    localparam logic [OP_W-1:0] OP_WRITE_A = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE_B = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH = 2'd2;

    typedef struct packed {
        logic              wr_a;
        logic              wr_b;
        logic              capture;
        logic              err;
        logic              clear_acc;
        logic              rd_en;
        logic [DEP_AW-1:0] k;
        logic              load_out;
    } cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } stat_t;

endpackage

// ===== hw/rtl/i8mm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i8mm_ctrl: controller for the int8 matrix multiply block
// Holds the size registers, decodes input transfers and sequences the
// inner-depth walk of each compute item.
// ----------------------------------------------------------------------------
module i8mm_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [i8mm_pkg::OP_W-1:0]       operation,
    input  logic [i8mm_pkg::IDX_W-1:0]      row_index,
    input  logic [i8mm_pkg::IDX_W-1:0]      col_index,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [i8mm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [i8mm_pkg::CFG_W-1:0]      cfg_data,
    input  i8mm_pkg::stat_t                 stat,
    output i8mm_pkg::cmd_t                  cmd
);
    import i8mm_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [CNT_W-1:0]   k_reg;
    logic [CNT_W-1:0]   k_next;
    logic [ROWS_W-1:0]  rows_reg;
    logic [COLS_W-1:0]  cols_reg;
    logic [DEPTH_W-1:0] depth_reg;

    logic [7:0]         rows_lim;
    logic [7:0]         cols_lim;
    logic [9:0]         depth_lim;
    logic [CNT_W-1:0]   k_last;
    logic               size_err;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);

    // Registers above the storage limits act as the limit
    assign rows_lim  = (8'(rows_reg) > 8'(MAX_ROWS)) ? 8'(MAX_ROWS) : 8'(rows_reg);
    assign cols_lim  = (8'(cols_reg) > 8'(MAX_COLS)) ? 8'(MAX_COLS) : 8'(cols_reg);
    assign depth_lim = (10'(depth_reg) > 10'(MAX_DEPTH)) ? 10'(MAX_DEPTH)
                                                         : 10'(depth_reg);
    assign k_last    = CNT_W'(depth_lim - 10'd1);
    assign size_err  = (8'(row_index) >= rows_lim) || (8'(col_index) >= cols_lim);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= ROWS_W'(16);
            cols_reg  <= COLS_W'(16);
            depth_reg <= DEPTH_W'(64);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ROWS:  rows_reg  <= cfg_data[ROWS_W-1:0];
                REG_COLS:  cols_reg  <= cfg_data[COLS_W-1:0];
                REG_DEPTH: depth_reg <= cfg_data[DEPTH_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        cmd        = '0;
        cmd.k      = k_reg[DEP_AW-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (operation)
                        OP_WRITE_A: cmd.wr_a = 1'b1;
                        OP_WRITE_B: cmd.wr_b = 1'b1;
                        OP_COMPUTE:
                        begin
                            cmd.capture   = 1'b1;
                            cmd.clear_acc = 1'b1;
                            cmd.err       = size_err;
                            k_next        = '0;
                            // error or zero depth: nothing to walk
                            if (size_err || (depth_lim == 10'd0))
                                state_next = S_DONE;
                            else
                                state_next = S_RUN;
                        end
                        default: ;
                    endcase
                end
            end
            S_RUN:
            begin
                cmd.rd_en = 1'b1;
                if (k_reg == k_last)
                    state_next = S_DRAIN;
                else
                    k_next = k_reg + CNT_W'(1);
            end
            S_DRAIN:
            begin
                if (!stat.pipe_busy)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

endmodule

// ===== hw/rtl/i8mm_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i8mm_datapath: storage and multiply-accumulate for the int8 matrix multiply
// Two element memories, registered reads, product register, accumulator,
// saturation and the result output register.
// ----------------------------------------------------------------------------
module i8mm_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  i8mm_pkg::cmd_t                      cmd,
    output i8mm_pkg::stat_t                     stat,
    input  logic [i8mm_pkg::IDX_W-1:0]          row_index,
    input  logic [i8mm_pkg::IDX_W-1:0]          col_index,
    input  logic signed [i8mm_pkg::ELEM_W-1:0]  value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [i8mm_pkg::SUM_W-1:0]   dot_sum,
    output logic [i8mm_pkg::IDX_W-1:0]          out_row,
    output logic [i8mm_pkg::IDX_W-1:0]          out_col,
    output logic                                index_error
);
    import i8mm_pkg::*;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((2 ** (SUM_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    logic [ELEM_W-1:0] left_mem  [A_DEPTH];
    logic [ELEM_W-1:0] right_mem [B_DEPTH];

    logic [IDX_W-1:0]          row_reg;
    logic [IDX_W-1:0]          col_reg;
    logic                      err_reg;
    logic signed [ELEM_W-1:0]  a_q_reg;
    logic signed [ELEM_W-1:0]  b_q_reg;
    logic signed [2*ELEM_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic                      rd_vld_reg;
    logic                      prod_vld_reg;
    logic                      out_valid_reg;
    logic signed [SUM_W-1:0]   dot_sum_reg;
    logic [IDX_W-1:0]          out_row_reg;
    logic [IDX_W-1:0]          out_col_reg;
    logic                      index_error_reg;

    logic                      wr_a_ok;
    logic                      wr_b_ok;
    logic [A_AW-1:0]           a_waddr;
    logic [B_AW-1:0]           b_waddr;
    logic [A_AW-1:0]           a_raddr;
    logic [B_AW-1:0]           b_raddr;
    logic signed [SUM_W-1:0]   sum_sat;

    // A[r][k] at r*MAX_DEPTH+k, B[k][c] at k*MAX_COLS+c
    assign wr_a_ok = cmd.wr_a && (int'(row_index) < MAX_ROWS) && (int'(col_index) < MAX_DEPTH);
    assign wr_b_ok = cmd.wr_b && (int'(row_index) < MAX_DEPTH) && (int'(col_index) < MAX_COLS);
    assign a_waddr = A_AW'(int'(row_index) * MAX_DEPTH + int'(col_index));
    assign b_waddr = B_AW'(int'(row_index) * MAX_COLS + int'(col_index));
    assign a_raddr = A_AW'(int'(row_reg) * MAX_DEPTH + int'(cmd.k));
    assign b_raddr = B_AW'(int'(cmd.k) * MAX_COLS + int'(col_reg));

    always_ff @(posedge clk)
    begin
        if (wr_a_ok)
            left_mem[a_waddr] <= value;
        if (cmd.rd_en)
            a_q_reg <= left_mem[a_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_b_ok)
            right_mem[b_waddr] <= value;
        if (cmd.rd_en)
            b_q_reg <= right_mem[b_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            row_reg <= row_index;
            col_reg <= col_index;
            err_reg <= cmd.err;
        end
        prod_reg <= a_q_reg * b_q_reg;
        if (cmd.clear_acc)
            acc_reg <= '0;
        else if (prod_vld_reg)
            acc_reg <= acc_reg + ACC_W'(prod_reg);
    end

    always_comb
    begin
        priority if (acc_reg > SAT_HI)
            sum_sat = SAT_HI[SUM_W-1:0];
        else if (acc_reg < SAT_LO)
            sum_sat = SAT_LO[SUM_W-1:0];
        else
            sum_sat = acc_reg[SUM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg    <= 1'b0;
            prod_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg   <= cmd.rd_en;
            prod_vld_reg <= rd_vld_reg;
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            dot_sum_reg     <= err_reg ? '0 : sum_sat;
            out_row_reg     <= row_reg;
            out_col_reg     <= col_reg;
            index_error_reg <= err_reg;
        end
    end

    assign stat.pipe_busy = rd_vld_reg || prod_vld_reg;
    assign stat.out_free  = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign dot_sum     = dot_sum_reg;
    assign out_row     = out_row_reg;
    assign out_col     = out_col_reg;
    assign index_error = index_error_reg;

endmodule

// ===== hw/rtl/int8_matrix_multiply.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int8_matrix_multiply: signed 8-bit matrix product, one result element per
// compute item
// Element writes fill the A and B tiles; a compute item returns the dot
// product of one A row and one B column over the configured depth.
// ----------------------------------------------------------------------------
// An A or B write transfer leaves the input side ready, and the next item is
// accepted in the following cycle. A compute transfer walks the inner depth,
// the depth register capped at MAX_DEPTH, with one multiply-accumulate per
// cycle through the single read port of each element memory, followed by a
// short drain of the read and product registers. An index error or a zero
// depth skips the walk and goes straight to loading the result.
// The finished result sits in an output register, so writes and the next
// compute item proceed while it waits; a compute result only waits to load
// if the previous result has not yet been taken. Size registers are written
// through the configuration port, which is always ready; elements never
// written read back as arbitrary values.
module int8_matrix_multiply (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [i8mm_pkg::OP_W-1:0]           operation,
    input  logic [i8mm_pkg::IDX_W-1:0]          row_index,
    input  logic [i8mm_pkg::IDX_W-1:0]          col_index,
    input  logic signed [i8mm_pkg::ELEM_W-1:0]  value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [i8mm_pkg::SUM_W-1:0]   dot_sum,
    output logic [i8mm_pkg::IDX_W-1:0]          out_row,
    output logic [i8mm_pkg::IDX_W-1:0]          out_col,
    output logic                                index_error,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [i8mm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [i8mm_pkg::CFG_W-1:0]          cfg_data
);
    import i8mm_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    i8mm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .row_index (row_index),
        .col_index (col_index),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stat      (stat),
        .cmd       (cmd)
    );

    i8mm_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .row_index   (row_index),
        .col_index   (col_index),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .dot_sum     (dot_sum),
        .out_row     (out_row),
        .out_col     (out_col),
        .index_error (index_error)
    );

endmodule

// ===== hw/rtl/i8mm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i8mm_checker: port-level checks for the int8 matrix multiply block
// Watches the top-level ports only; attached by the bind below.
// ----------------------------------------------------------------------------
module i8mm_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic [i8mm_pkg::OP_W-1:0]           operation,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic signed [i8mm_pkg::SUM_W-1:0]   dot_sum,
    input logic [i8mm_pkg::IDX_W-1:0]          out_row,
    input logic [i8mm_pkg::IDX_W-1:0]          out_col,
    input logic                                index_error
);
    import i8mm_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(dot_sum)
            && $stable(out_row) && $stable(out_col) && $stable(index_error))
        else $error("result changed while stalled");

    // an index error always reports a zero sum
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && index_error |-> dot_sum == '0)
        else $error("index error with nonzero sum");

    // a compute transfer keeps the input side busy in the next cycle
    a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && operation == OP_COMPUTE |=> in_stall)
        else $error("input not stalled after compute transfer");

    // any other transfer leaves the block ready for the next item
    a_write_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && operation != OP_COMPUTE |=> !in_stall)
        else $error("input stalled after write transfer");

endmodule

bind int8_matrix_multiply i8mm_checker u_checker (.*);
